FILE: rtl/core/cmop_pkg.sv
// shared types and constants for the coap message option parser
package cmop_pkg;

  localparam int NUM_W      = 20;
  localparam int LEN_W      = 17;
  localparam int OFF_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [NUM_W-1:0] NUM_MAX = 20'hFFFFF;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_PRESENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOKEN_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_NUMBER  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SHORT     = 2'd1;
  localparam logic [1:0] ST_BAD       = 2'd2;
  localparam logic [1:0] ST_TOO_LONG  = 2'd3;

  // record kinds
  localparam logic KIND_OPTION = 1'b0;
  localparam logic KIND_END    = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [NUM_W-1:0] option_number;
    logic [LEN_W-1:0] value_length;
    logic [OFF_W-1:0] value_offset;
    logic [1:0]       status;
    logic [OFF_W-1:0] payload_index;
    logic [1:0]       msg_type;
    logic [7:0]       msg_code;
    logic [15:0]      message_id;
    logic [3:0]       token_length;
    logic             target_found;
    logic [63:0]      target_value;
  } result_t;

  // up to two records produced by one accepted byte
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

FILE: rtl/core/coap_message_option_parser_unit.sv
// top level: streaming coap message parser emitting option and end-of-message records
//
//  channel | direction | handshake           | beat carries
//  --------+-----------+---------------------+------------------------------------------
//  in      | into      | in_valid / in_stall | data_byte, last_byte
//  out     | out of    | out_valid/out_stall | one option record or end record
//  cfg     | into      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one byte per cycle while in_stall is low: the byte is decoded against the parse state in the
// cycle it is taken and its records land in a four-deep result queue; a byte closing both an
// option and the message yields two beats, so the queue sets the pace when out is stalled
// in_stall rises while the queue holds three or more records
// rst (synchronous) loads the register defaults and clears parse state and queue
// cfg_ready is always high
module coap_message_option_parser_unit import cmop_pkg::*; #(
  parameter int MAX_MSG_BYTES = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  // input beats
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  // result beats
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  kind,
  output logic [NUM_W-1:0]      option_number,
  output logic [LEN_W-1:0]      value_length,
  output logic [OFF_W-1:0]      value_offset,
  output logic [1:0]            status,
  output logic [OFF_W-1:0]      payload_index,
  output logic [1:0]            msg_type,
  output logic [7:0]            msg_code,
  output logic [15:0]           message_id,
  output logic [3:0]            token_length,
  output logic                  target_found,
  output logic [63:0]           target_value,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // byte index must also hold the saturated value one past the limit
  localparam int IW = $clog2(MAX_MSG_BYTES + 2);

  typedef enum logic [3:0] {
    PH_H0, PH_H1, PH_H2, PH_H3, PH_TOK, PH_OPT, PH_DHI, PH_DLO,
    PH_LHI, PH_LLO, PH_VAL, PH_PAY, PH_STOP
  } phase_t;

  // configuration registers
  logic             header_present;
  logic [3:0]       max_token_len;
  logic [NUM_W-1:0] target_number;

  // parse state
  logic [IW-1:0]    byte_index,       byte_index_next;
  phase_t           phase,            phase_next;
  logic             hdr_mode,         hdr_mode_next;
  logic [7:0]       first_header_byte, first_header_byte_next;
  logic [7:0]       code_byte,        code_byte_next;
  logic [15:0]      id_word,          id_word_next;
  logic [3:0]       token_left,       token_left_next;
  logic [NUM_W-1:0] running_number,   running_number_next;
  logic [LEN_W-1:0] delta_accum,      delta_accum_next;
  logic [LEN_W-1:0] length_accum,     length_accum_next;
  logic [LEN_W-1:0] value_bytes_left, value_bytes_left_next;
  logic [1:0]       parse_status,     parse_status_next;
  logic [IW-1:0]    payload_start,    payload_start_next;
  logic             capture_active,   capture_active_next;
  logic             found_flag,       found_flag_next;
  logic [63:0]      captured_value,   captured_value_next;

  // decode helpers
  logic             in_accept;
  logic             hdr_eff;
  phase_t           ph;
  logic             over;
  logic [IW-1:0]    idx_plus;
  logic             after_delta;
  logic             hdr_done;
  logic             err;
  logic [1:0]       err_code;
  logic [LEN_W-1:0] d_use;
  logic [LEN_W-1:0] l_use;
  logic [NUM_W:0]   num_sum;
  logic             hit;
  logic             opt_emit;
  logic [1:0]       end_st;
  result_t          rec_opt;
  result_t          rec_end;
  push_t            push;
  result_t          head;
  logic             q_full;

  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    // header mode and start phase are taken when the first byte of a message arrives
    hdr_eff = (byte_index == '0) ? header_present : hdr_mode;
    ph      = (byte_index == '0) ? (header_present ? PH_H0 : PH_OPT) : phase;
    over    = (byte_index >= IW'(MAX_MSG_BYTES));
    idx_plus = byte_index + IW'(1);

    hdr_mode_next          = hdr_eff;
    phase_next             = ph;
    first_header_byte_next = first_header_byte;
    code_byte_next         = code_byte;
    id_word_next           = id_word;
    token_left_next        = token_left;
    running_number_next    = running_number;
    delta_accum_next       = delta_accum;
    length_accum_next      = length_accum;
    value_bytes_left_next  = value_bytes_left;
    parse_status_next      = parse_status;
    payload_start_next     = payload_start;
    capture_active_next    = capture_active;
    found_flag_next        = found_flag;
    captured_value_next    = captured_value;

    after_delta = 1'b0;
    hdr_done    = 1'b0;
    err         = 1'b0;
    err_code    = ST_OK;
    d_use       = '0;
    l_use       = '0;
    num_sum     = '0;
    hit         = 1'b0;
    opt_emit    = 1'b0;
    rec_opt     = '0;

    if (over) begin
      err      = 1'b1;
      err_code = ST_TOO_LONG;
    end else begin
      case (ph)
        PH_H0: begin
          first_header_byte_next = data_byte;
          if ((data_byte[7:6] != 2'd1) || (data_byte[3:0] > max_token_len)) begin
            err      = 1'b1;
            err_code = ST_BAD;
          end else begin
            phase_next = PH_H1;
          end
        end
        PH_H1: begin
          code_byte_next = data_byte;
          phase_next     = PH_H2;
        end
        PH_H2: begin
          id_word_next = {data_byte, 8'h00};
          phase_next   = PH_H3;
        end
        PH_H3: begin
          id_word_next    = {id_word[15:8], data_byte};
          token_left_next = first_header_byte[3:0];
          phase_next      = (first_header_byte[3:0] != 4'd0) ? PH_TOK : PH_OPT;
        end
        PH_TOK: begin
          token_left_next = token_left - 4'd1;
          if (token_left_next == 4'd0) begin
            phase_next = PH_OPT;
          end
        end
        PH_OPT: begin
          if (data_byte == 8'hFF) begin
            // payload marker
            payload_start_next = idx_plus;
            phase_next         = PH_PAY;
          end else begin
            delta_accum_next  = LEN_W'(data_byte[7:4]);
            length_accum_next = LEN_W'(data_byte[3:0]);
            case (data_byte[7:4])
              4'd15: begin
                err      = 1'b1;
                err_code = ST_BAD;
              end
              4'd14: phase_next = PH_DHI;
              4'd13: phase_next = PH_DLO;
              default: begin
                after_delta = 1'b1;
                d_use       = LEN_W'(data_byte[7:4]);
                l_use       = LEN_W'(data_byte[3:0]);
              end
            endcase
          end
        end
        PH_DHI: begin
          delta_accum_next = LEN_W'({data_byte, 8'h00}) + LEN_W'(269);
          phase_next       = PH_DLO;
        end
        PH_DLO: begin
          delta_accum_next = delta_accum + LEN_W'(data_byte);
          after_delta      = 1'b1;
          d_use            = delta_accum_next;
          l_use            = length_accum;
        end
        PH_LHI: begin
          length_accum_next = LEN_W'({data_byte, 8'h00}) + LEN_W'(269);
          phase_next        = PH_LLO;
        end
        PH_LLO: begin
          length_accum_next = length_accum + LEN_W'(data_byte);
          hdr_done          = 1'b1;
          d_use             = delta_accum;
          l_use             = length_accum_next;
        end
        PH_VAL: begin
          if (capture_active) begin
            captured_value_next = {captured_value[55:0], data_byte};
          end
          value_bytes_left_next = value_bytes_left - LEN_W'(1);
          if (value_bytes_left_next == '0) begin
            if (capture_active) begin
              found_flag_next = 1'b1;
            end
            capture_active_next = 1'b0;
            phase_next          = PH_OPT;
          end
        end
        default: begin
        end
      endcase
    end

    byte_index_next = over ? IW'(MAX_MSG_BYTES + 1) : idx_plus;

    // length nibble of a short option header
    if (after_delta) begin
      case (l_use[3:0])
        4'd15: begin
          err      = 1'b1;
          err_code = ST_BAD;
        end
        4'd14: phase_next = PH_LHI;
        4'd13: phase_next = PH_LLO;
        default: hdr_done = 1'b1;
      endcase
    end

    // option header complete: advance the running number and emit the record
    if (hdr_done) begin
      num_sum             = {1'b0, running_number} + (NUM_W + 1)'(d_use);
      running_number_next = (num_sum > {1'b0, NUM_MAX}) ? NUM_MAX : num_sum[NUM_W-1:0];
      opt_emit            = 1'b1;
      rec_opt.kind          = KIND_OPTION;
      rec_opt.option_number = running_number_next;
      rec_opt.value_length  = l_use;
      rec_opt.value_offset  = OFF_W'(idx_plus);
      hit = !found_flag && (running_number_next == target_number);
      if (hit) begin
        captured_value_next = '0;
      end
      if (l_use == '0) begin
        if (hit) begin
          found_flag_next = 1'b1;
        end
        phase_next = PH_OPT;
      end else begin
        capture_active_next   = hit;
        value_bytes_left_next = l_use;
        phase_next            = PH_VAL;
      end
    end

    // first error wins, parsing stops
    if (err) begin
      if (parse_status == ST_OK) begin
        parse_status_next = err_code;
      end
      phase_next = PH_STOP;
    end

    // end-of-message status
    if (hdr_eff && (byte_index_next < IW'(4))) begin
      end_st = ST_SHORT;
    end else if (parse_status_next != ST_OK) begin
      end_st = parse_status_next;
    end else if (hdr_eff &&
                 (byte_index_next < IW'(4) + IW'(first_header_byte_next[3:0]))) begin
      end_st = ST_SHORT;
    end else if ((phase_next == PH_DHI) || (phase_next == PH_DLO) ||
                 (phase_next == PH_LHI) || (phase_next == PH_LLO) ||
                 (phase_next == PH_VAL)) begin
      end_st = ST_BAD;
    end else begin
      end_st = ST_OK;
    end

    rec_end = '0;
    rec_end.kind   = KIND_END;
    rec_end.status = end_st;
    if (end_st == ST_OK) begin
      rec_end.payload_index = (phase_next == PH_PAY) ? OFF_W'(payload_start_next)
                                                     : OFF_W'(byte_index_next);
    end
    rec_end.msg_type     = first_header_byte_next[5:4];
    rec_end.msg_code     = code_byte_next;
    rec_end.message_id   = id_word_next;
    rec_end.token_length = first_header_byte_next[3:0];
    rec_end.target_found = found_flag_next;
    rec_end.target_value = found_flag_next ? captured_value_next : 64'd0;

    // records handed to the queue for this beat
    push.cnt = '0;
    push.r0  = opt_emit ? rec_opt : rec_end;
    push.r1  = rec_end;
    if (in_accept) begin
      push.cnt = 2'(opt_emit) + 2'(last_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_present    <= 1'b1;
      max_token_len     <= 4'd8;
      target_number     <= '0;
      byte_index        <= '0;
      phase             <= PH_H0;
      hdr_mode          <= 1'b1;
      first_header_byte <= '0;
      code_byte         <= '0;
      id_word           <= '0;
      token_left        <= '0;
      running_number    <= '0;
      delta_accum       <= '0;
      length_accum      <= '0;
      value_bytes_left  <= '0;
      parse_status      <= ST_OK;
      payload_start     <= '0;
      capture_active    <= 1'b0;
      found_flag        <= 1'b0;
      captured_value    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HEADER_PRESENT: header_present <= cfg_data[0];
          CFG_MAX_TOKEN_LEN:  max_token_len  <= cfg_data[3:0];
          CFG_TARGET_NUMBER:  target_number  <= cfg_data[NUM_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_accept) begin
        if (last_byte) begin
          // message closed: back to a clean slate, start phase chosen on the next first byte
          byte_index        <= '0;
          phase             <= PH_H0;
          hdr_mode          <= header_present;
          first_header_byte <= '0;
          code_byte         <= '0;
          id_word           <= '0;
          token_left        <= '0;
          running_number    <= '0;
          delta_accum       <= '0;
          length_accum      <= '0;
          value_bytes_left  <= '0;
          parse_status      <= ST_OK;
          payload_start     <= '0;
          capture_active    <= 1'b0;
          found_flag        <= 1'b0;
          captured_value    <= '0;
        end else begin
          byte_index        <= byte_index_next;
          phase             <= phase_next;
          hdr_mode          <= hdr_mode_next;
          first_header_byte <= first_header_byte_next;
          code_byte         <= code_byte_next;
          id_word           <= id_word_next;
          token_left        <= token_left_next;
          running_number    <= running_number_next;
          delta_accum       <= delta_accum_next;
          length_accum      <= length_accum_next;
          value_bytes_left  <= value_bytes_left_next;
          parse_status      <= parse_status_next;
          payload_start     <= payload_start_next;
          capture_active    <= capture_active_next;
          found_flag        <= found_flag_next;
          captured_value    <= captured_value_next;
        end
      end
    end
  end

  // result queue doubles as the output register
  cmop_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .full      (q_full)
  );

  assign kind           = head.kind;
  assign option_number  = head.option_number;
  assign value_length   = head.value_length;
  assign value_offset   = head.value_offset;
  assign status         = head.status;
  assign payload_index  = head.payload_index;
  assign msg_type       = head.msg_type;
  assign msg_code       = head.msg_code;
  assign message_id     = head.message_id;
  assign token_length   = head.token_length;
  assign target_found   = head.target_found;
  assign target_value   = head.target_value;

endmodule

FILE: rtl/core/cmop_result_queue.sv
// small compacting queue of result records between the parser and the output channel
module cmop_result_queue import cmop_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t head,
  output logic    full
);

  localparam int DEPTH = 4;
  localparam int CW    = $clog2(DEPTH + 1);

  result_t         q [DEPTH];
  result_t         q_next [DEPTH];
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [CW-1:0]   base;
  logic            pop;

  always_comb begin
    pop  = (count != '0) && !out_stall;
    base = count - CW'(pop);
    for (int i = 0; i < DEPTH; i++) begin
      q_next[i] = q[i];
      if (CW'(i) < base) begin
        if (pop && (i + 1 < DEPTH)) begin
          q_next[i] = q[(i + 1) % DEPTH];
        end
      end else if ((CW'(i) == base) && (push.cnt != 2'd0)) begin
        q_next[i] = push.r0;
      end else if ((CW'(i) == base + CW'(1)) && (push.cnt == 2'd2)) begin
        q_next[i] = push.r1;
      end
    end
    count_next = base + CW'(push.cnt);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      q[i] <= q_next[i];
    end
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign out_valid = (count != '0);
  assign head      = q[0];
  // room for two records must be left before a byte is taken
  assign full      = (count > CW'(DEPTH - 2));

endmodule

FILE: tb/tb_coap_message_option_parser_unit.sv
// self-checking testbench for the streaming coap message option parser
module tb_coap_message_option_parser_unit;
  import cmop_pkg::*;

  localparam int          MSG_LIMIT   = 2048;
  localparam int unsigned RANDOM_BEATS = 1850;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // parse positions inside one message
  typedef enum logic [3:0] {
    S_FLAGS, S_CODE, S_ID_HI, S_ID_LO, S_TOKEN, S_OPT_HDR, S_DELTA_HI, S_DELTA_LO,
    S_LEN_HI, S_LEN_LO, S_VALUE, S_PAYLOAD, S_HALT
  } parse_pos_t;

  // one row of the directed table; typed rows carry the end status read straight off the spec
  typedef struct packed {
    logic [7:0] d;
    logic       l;
    logic       typed;
    logic [1:0] st;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            data_byte = 8'h00;
  logic                  last_byte = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  kind;
  logic [NUM_W-1:0]      option_number;
  logic [LEN_W-1:0]      value_length;
  logic [OFF_W-1:0]      value_offset;
  logic [1:0]            status;
  logic [OFF_W-1:0]      payload_index;
  logic [1:0]            msg_type;
  logic [7:0]            msg_code;
  logic [15:0]           message_id;
  logic [3:0]            token_length;
  logic                  target_found;
  logic [63:0]           target_value;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_HEADER_PRESENT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  coap_message_option_parser_unit #(.MAX_MSG_BYTES(MSG_LIMIT)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
    .option_number(option_number), .value_length(value_length),
    .value_offset(value_offset), .status(status), .payload_index(payload_index),
    .msg_type(msg_type), .msg_code(msg_code), .message_id(message_id),
    .token_length(token_length), .target_found(target_found), .target_value(target_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // parser mirror: register copies and per-message parse state
  // ---------------------------------------------------------------------------
  logic             cfg_hdr;
  logic [3:0]       cfg_max_tok;
  logic [NUM_W-1:0] cfg_target;

  int unsigned m_index, m_number, m_delta, m_len, m_left, m_payload, m_tok_left;
  parse_pos_t  m_phase;
  logic [7:0]  m_flags, m_code;
  logic [15:0] m_id;
  logic [1:0]  m_status;
  logic        m_capture, m_found, m_hdr;
  logic [63:0] m_value;

  result_t     expected_records[$];
  logic [7:0]  msg_bytes[$];
  int unsigned bytes_sent = 0;
  int unsigned cycles = 0;
  int          mismatches = 0;
  bit          steady = 1'b0;   // no gaps on either side while set

  // directed beats: short header, bad version, token over limit, token cut short,
  // reserved delta nibble, then a tidy message that hits option zero and ends on the marker
  dir_row_t directed_rows [25] = '{
    '{8'h40, 1'b1, 1'b1, ST_SHORT},
    '{8'hC0, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b1, 1'b1, ST_BAD},
    '{8'h4F, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b1, 1'b1, ST_BAD},
    '{8'h41, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b1, 1'b1, ST_SHORT},
    '{8'h70, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'hF0, 1'b1, 1'b1, ST_BAD},
    '{8'h40, 1'b0, 1'b0, ST_OK}, '{8'h01, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h01, 1'b0, 1'b0, ST_OK}, '{8'h01, 1'b0, 1'b0, ST_OK}, '{8'h2A, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b1, 1'b0, ST_OK}
  };

  function automatic void clear_message();
    m_index = 0; m_flags = '0; m_code = '0; m_id = '0;
    m_number = 0; m_delta = 0; m_len = 0; m_left = 0;
    m_status = ST_OK; m_payload = 0; m_tok_left = 0;
    m_capture = 1'b0; m_found = 1'b0; m_value = '0;
    m_hdr = cfg_hdr;
    m_phase = m_hdr ? S_FLAGS : S_OPT_HDR;
  endfunction

  // first error wins, parsing stops for the rest of the message
  function automatic void halt(input logic [1:0] st);
    if (m_status == ST_OK) m_status = st;
    m_phase = S_HALT;
  endfunction

  function automatic result_t make_record(input logic k, input int unsigned num,
                                          input int unsigned len, input int unsigned voff,
                                          input logic [1:0] st, input int unsigned poff,
                                          input logic full);
    result_t r;
    r.kind           = k;
    r.option_number  = NUM_W'(num);
    r.value_length   = LEN_W'(len);
    r.value_offset   = OFF_W'(voff);
    r.status         = st;
    r.payload_index  = OFF_W'(poff);
    r.msg_type       = full ? m_flags[5:4] : 2'd0;
    r.msg_code       = full ? m_code : 8'd0;
    r.message_id     = full ? m_id : 16'd0;
    r.token_length   = full ? m_flags[3:0] : 4'd0;
    r.target_found   = full && m_found;
    r.target_value   = (full && m_found) ? m_value : 64'd0;
    return r;
  endfunction

  // option header complete: running number saturates, then the value (if any) follows
  function automatic void option_done(input int unsigned idx);
    int unsigned sum;
    logic        hit;
    sum = m_number + m_delta;
    m_number = (sum > NUM_MAX) ? NUM_MAX : sum;
    expected_records.push_back(make_record(KIND_OPTION, m_number, m_len, idx + 1,
                                           ST_OK, 0, 1'b0));
    hit = !m_found && (m_number == cfg_target);
    if (hit) m_value = '0;
    if (m_len == 0) begin
      if (hit) m_found = 1'b1;
      m_phase = S_OPT_HDR;
    end else begin
      m_capture = hit;
      m_left = m_len;
      m_phase = S_VALUE;
    end
  endfunction

  function automatic void length_stage(input int unsigned idx);
    if (m_len == 15) halt(ST_BAD);
    else if (m_len == 14) m_phase = S_LEN_HI;
    else if (m_len == 13) m_phase = S_LEN_LO;
    else option_done(idx);
  endfunction

  function automatic void consume_byte(input logic [7:0] d, input int unsigned idx);
    case (m_phase)
      S_FLAGS: begin
        m_flags = d;
        if (d[7:6] != 2'b01 || d[3:0] > cfg_max_tok) halt(ST_BAD);
        else m_phase = S_CODE;
      end
      S_CODE: begin
        m_code = d;
        m_phase = S_ID_HI;
      end
      S_ID_HI: begin
        m_id = {d, 8'h00};
        m_phase = S_ID_LO;
      end
      S_ID_LO: begin
        m_id[7:0] = d;
        m_tok_left = m_flags[3:0];
        m_phase = (m_tok_left != 0) ? S_TOKEN : S_OPT_HDR;
      end
      S_TOKEN: begin
        m_tok_left--;
        if (m_tok_left == 0) m_phase = S_OPT_HDR;
      end
      S_OPT_HDR: begin
        if (d == 8'hFF) begin
          m_payload = idx + 1;
          m_phase = S_PAYLOAD;
        end else begin
          m_delta = d[7:4];
          m_len = d[3:0];
          if (m_delta == 15) halt(ST_BAD);
          else if (m_delta == 14) m_phase = S_DELTA_HI;
          else if (m_delta == 13) m_phase = S_DELTA_LO;
          else length_stage(idx);
        end
      end
      S_DELTA_HI: begin
        m_delta = d * 256 + 269;
        m_phase = S_DELTA_LO;
      end
      S_DELTA_LO: begin
        m_delta += d;
        length_stage(idx);
      end
      S_LEN_HI: begin
        m_len = d * 256 + 269;
        m_phase = S_LEN_LO;
      end
      S_LEN_LO: begin
        m_len += d;
        option_done(idx);
      end
      S_VALUE: begin
        if (m_capture) m_value = {m_value[55:0], d};
        m_left--;
        if (m_left == 0) begin
          if (m_capture) m_found = 1'b1;
          m_capture = 1'b0;
          m_phase = S_OPT_HDR;
        end
      end
      default: ;
    endcase
  endfunction

  // one accepted input beat: option record as the header closes, end record on the last byte
  function automatic void parse_byte(input logic [7:0] d, input logic l);
    int unsigned idx, len, poff;
    logic [1:0]  st;
    if (m_index == 0) begin
      m_hdr = cfg_hdr;
      m_phase = m_hdr ? S_FLAGS : S_OPT_HDR;
    end
    idx = m_index;
    if (idx >= MSG_LIMIT) halt(ST_TOO_LONG);
    else consume_byte(d, idx);
    m_index = (idx >= MSG_LIMIT) ? MSG_LIMIT + 1 : idx + 1;
    if (!l) return;
    len = m_index;
    if (m_hdr && len < 4) st = ST_SHORT;
    else if (m_status != ST_OK) st = m_status;
    else if (m_hdr && len < 4 + m_flags[3:0]) st = ST_SHORT;
    else if (m_phase == S_DELTA_HI || m_phase == S_DELTA_LO || m_phase == S_LEN_HI ||
             m_phase == S_LEN_LO || m_phase == S_VALUE) st = ST_BAD;
    else st = ST_OK;
    poff = (st != ST_OK) ? 0 : ((m_phase == S_PAYLOAD) ? m_payload : len);
    expected_records.push_back(make_record(KIND_END, 0, 0, 0, st, poff, 1'b1));
    clear_message();
  endfunction

  // ---------------------------------------------------------------------------
  // message builder
  // ---------------------------------------------------------------------------
  function automatic logic [3:0] ext_nibble(input int unsigned v);
    return (v < 13) ? 4'(v) : ((v < 269) ? 4'd13 : 4'd14);
  endfunction

  function automatic void push_ext(input int unsigned v);
    if (v >= 269) begin
      msg_bytes.push_back(8'((v - 269) >> 8));
      msg_bytes.push_back(8'(v - 269));
    end else if (v >= 13) begin
      msg_bytes.push_back(8'(v - 13));
    end
  endfunction

  // mostly well formed messages with random content; about a tenth pure noise,
  // some cut short, a few with reserved nibbles, and some long runs of wide deltas
  // that drive the option number into saturation
  function automatic void build_message();
    int unsigned sel, sel2, tkl, n_opt, running, delta, len, cut;
    logic [7:0]  first;
    logic        big, cut_short, huge;
    msg_bytes.delete();
    sel = $urandom_range(99);
    if (sel < 10) begin
      repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom));
      return;
    end
    big = (sel >= 90);
    cut_short = (sel < 26);
    if (cfg_hdr) begin
      tkl = (sel < 16) ? $urandom_range(15) : $urandom_range(cfg_max_tok);
      first = {2'b01, 2'($urandom), 4'(tkl)};
      if (sel < 20) first[7:6] = 2'($urandom);
      msg_bytes.push_back(first);
      repeat (3 + tkl) msg_bytes.push_back(8'($urandom));
    end
    running = 0;
    n_opt = big ? $urandom_range(18, 22) : $urandom_range(0, 5);
    repeat (n_opt) begin
      if ($urandom_range(99) < 3)
        msg_bytes.push_back($urandom_range(1) ? {4'hF, 4'($urandom)} : {4'($urandom), 4'hF});
      sel2 = $urandom_range(99);
      if (big) delta = $urandom_range(60000, 65804);
      else if (sel2 < 30 && cfg_target >= running && cfg_target - running <= 65804)
        delta = cfg_target - running;
      else if (sel2 < 65) delta = $urandom_range(12);
      else if (sel2 < 88) delta = $urandom_range(13, 268);
      else delta = $urandom_range(269, 65804);
      sel2 = $urandom_range(99);
      huge = cut_short && sel2 >= 85;
      if (huge) len = $urandom_range(269, 65804);
      else if (sel2 < 30) len = 0;
      else if (sel2 < 85) len = $urandom_range(1, 12);
      else if (sel2 < 95) len = $urandom_range(13, 40);
      else len = $urandom_range(269, 300);
      running += delta;
      msg_bytes.push_back({ext_nibble(delta), ext_nibble(len)});
      push_ext(delta);
      push_ext(len);
      if (huge) begin
        // value far longer than the message: truncated inside the value
        repeat ($urandom_range(8)) msg_bytes.push_back(8'($urandom));
        break;
      end
      repeat (len) msg_bytes.push_back(8'($urandom));
    end
    if ($urandom_range(1)) begin
      msg_bytes.push_back(8'hFF);
      repeat ($urandom_range(6)) msg_bytes.push_back(8'($urandom));
    end
    if (msg_bytes.size() == 0) msg_bytes.push_back(8'($urandom));
    if (cut_short) begin
      cut = $urandom_range(1, msg_bytes.size());
      while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  // random gap first, then hold the beat until it is taken
  task automatic send_byte(input logic [7:0] d, input logic l);
    if (!steady && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!steady && $urandom_range(99) < 37);
    end
    in_valid  <= 1'b1;
    data_byte <= d;
    last_byte <= l;
    do @(posedge clk); while (in_stall);
    parse_byte(d, l);
    bytes_sent++;
    steady = (bytes_sent >= 700 && bytes_sent < 1000);
  endtask

  task automatic send_message();
    foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
  endtask

  // caller drops cfg_valid once the whole burst of writes is done
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_HEADER_PRESENT: cfg_hdr = val[0];
      CFG_MAX_TOKEN_LEN:  cfg_max_tok = val[3:0];
      CFG_TARGET_NUMBER:  cfg_target = val[NUM_W-1:0];
      default: ;
    endcase
  endtask

  // wait for every outstanding record, then a few cycles more for good measure
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, field-by-field compare against the oldest record
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_record();
    result_t want;
    if (expected_records.size() == 0) begin
      $display("%0t: record with nothing expected, kind %0b status %0d number %0h", $time,
               kind, status, option_number);
      mismatches++;
      return;
    end
    want = expected_records.pop_front();
    check_field("kind", want.kind, kind);
    check_field("option_number", want.option_number, option_number);
    check_field("value_length", want.value_length, value_length);
    check_field("value_offset", want.value_offset, value_offset);
    check_field("status", want.status, status);
    check_field("payload_index", want.payload_index, payload_index);
    check_field("msg_type", want.msg_type, msg_type);
    check_field("msg_code", want.msg_code, msg_code);
    check_field("message_id", want.message_id, message_id);
    check_field("token_length", want.token_length, token_length);
    check_field("target_found", want.target_found, target_found);
    check_field("target_value", want.target_value, target_value);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_record();
    out_stall <= !steady && ($urandom_range(99) < 37);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic             hdr;
    logic [3:0]       tok;
    logic [NUM_W-1:0] tgt;
    int unsigned      stop_at;

    // register defaults as after reset
    cfg_hdr = 1'b1;
    cfg_max_tok = 4'd8;
    cfg_target = '0;
    clear_message();

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table under the reset settings
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].d, directed_rows[i].l);
      if (directed_rows[i].typed && expected_records[$].status !== directed_rows[i].st) begin
        $display("%0t: directed row %0d status expected %0d predicted %0d", $time, i,
                 directed_rows[i].st, expected_records[$].status);
        mismatches++;
      end
    end

    // random phases, each under its own register setting; extremes first
    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: begin hdr = 1'b1; tok = 4'd15; tgt = '0; end
        1: begin hdr = 1'b0; tok = 4'd0;  tgt = NUM_MAX; end
        2: begin hdr = 1'b1; tok = 4'd0;  tgt = NUM_W'($urandom_range(30)); end
        3: begin hdr = 1'b1; tok = 4'($urandom); tgt = NUM_MAX; end
        default: begin
          hdr = 1'($urandom);
          tok = 4'($urandom);
          tgt = $urandom_range(1) ? NUM_W'($urandom_range(40)) : NUM_W'($urandom);
        end
      endcase
      // unused upper data bits are randomised, the block keeps only the low ones
      write_reg(CFG_HEADER_PRESENT, {19'($urandom), hdr});
      write_reg(CFG_MAX_TOKEN_LEN, {16'($urandom), tok});
      write_reg(CFG_TARGET_NUMBER, tgt);
      cfg_valid <= 1'b0;

      // one oversized message in two of the phases: bytes past the limit give too long
      if (p == 1 || p == 4) begin
        msg_bytes.delete();
        if (cfg_hdr) begin
          msg_bytes.push_back(8'h40);
          msg_bytes.push_back(8'h00);
          msg_bytes.push_back(8'($urandom));
          msg_bytes.push_back(8'($urandom));
        end
        msg_bytes.push_back(8'hFF);
        while (msg_bytes.size() < MSG_LIMIT + 2) msg_bytes.push_back(8'($urandom));
        send_message();
      end

      stop_at = bytes_sent + RANDOM_BEATS / 8;
      while (bytes_sent < stop_at) begin
        build_message();
        send_message();
      end
    end

    settle();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
